// ----- hw/rtl/abb_pkg.sv -----
// ----------------------------------------------------------------------------
// abb_pkg
// Shared types and constants for the affine box bounds block: transaction
// payload structs, fixed-point widths and register map.
// ----------------------------------------------------------------------------
package abb_pkg;

   // fixed-point format of all values
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 32;

   // full product and its truncated form
   localparam int MUL_W  = 2 * VAL_W;
   localparam int PROD_W = MUL_W - FRAC_BITS;

   // two products plus an offset never overflow this width
   localparam int SUM_W = PROD_W + 2;

   // 1.0 in the fixed-point format
   localparam logic signed [VAL_W-1:0] Q_ONE = VAL_W'(1) << FRAC_BITS;

   // saturation bounds at accumulator width
   localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

   // register map: word index taken from paddr[4:2]
   localparam int ADDR_W = 5;
   localparam int IDX_W  = 3;
   localparam logic [IDX_W-1:0] REG_COEF_A   = 3'd0;
   localparam logic [IDX_W-1:0] REG_COEF_B   = 3'd1;
   localparam logic [IDX_W-1:0] REG_COEF_C   = 3'd2;
   localparam logic [IDX_W-1:0] REG_COEF_D   = 3'd3;
   localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd4;
   localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd5;

   // input transaction: two opposite corners
   typedef struct packed {
      logic signed [VAL_W-1:0] x_first;
      logic signed [VAL_W-1:0] y_first;
      logic signed [VAL_W-1:0] x_second;
      logic signed [VAL_W-1:0] y_second;
   } req_type;

   // result transaction: bounds of the mapped box
   typedef struct packed {
      logic signed [VAL_W-1:0] x_low;
      logic signed [VAL_W-1:0] y_low;
      logic signed [VAL_W-1:0] x_high;
      logic signed [VAL_W-1:0] y_high;
   } rsp_type;

   // clamp an accumulator value to the signed 32-bit range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[VAL_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/affine_box_bounds.sv -----
// ----------------------------------------------------------------------------
// affine_box_bounds
// Axis-aligned bounds of a box under a 2D affine map held in six registers.
// ----------------------------------------------------------------------------
//  channel   | ports                                | payload
//  ----------+--------------------------------------+-----------------------
//  input     | req_valid, req_stall, req_data       | abb_pkg::req_type
//  result    | rsp_valid, rsp_stall, rsp_data       | abb_pkg::rsp_type
//  config    | psel, penable, pwrite, paddr, pwdata,| 32-bit registers at
//            | prdata, pready                       | byte address 4*index
//
//  One transaction enters per cycle while req_stall is low; rsp_valid
//  rises behind five registers (input register, eight parallel
//  32x32 multipliers, offset adders, pairwise min/max, final min/max with
//  saturation). Reset clears all stage valid bits and loads the identity
//  matrix. A stall on the result side holds the output stage and every
//  occupied stage in an unbroken run behind it; req_stall rises only
//  while all five stages are full and the result is stalled.
// ----------------------------------------------------------------------------
module affine_box_bounds (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  abb_pkg::req_type            req_data,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output abb_pkg::rsp_type            rsp_data,
   // configuration
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [abb_pkg::ADDR_W-1:0]  paddr,
   input  logic [abb_pkg::VAL_W-1:0]   pwdata,
   output logic [abb_pkg::VAL_W-1:0]   prdata,
   output logic                        pready
);

   localparam int STAGES = 5;

   // configuration registers
   logic signed [abb_pkg::VAL_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [abb_pkg::VAL_W-1:0] offset_x_ff, offset_y_ff;

   // pipeline control
   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] free;

   // stage data
   abb_pkg::req_type                  in_ff;
   logic signed [abb_pkg::PROD_W-1:0] p_ax1_ff, p_ax2_ff, p_cy1_ff, p_cy2_ff;
   logic signed [abb_pkg::PROD_W-1:0] p_bx1_ff, p_bx2_ff, p_dy1_ff, p_dy2_ff;
   logic signed [abb_pkg::SUM_W-1:0]  qx_ff [4];
   logic signed [abb_pkg::SUM_W-1:0]  qy_ff [4];
   logic signed [abb_pkg::SUM_W-1:0]  xlo_a_ff, xhi_a_ff, xlo_b_ff, xhi_b_ff;
   logic signed [abb_pkg::SUM_W-1:0]  ylo_a_ff, yhi_a_ff, ylo_b_ff, yhi_b_ff;
   abb_pkg::rsp_type                  rsp_ff;

   logic wr_en;
   logic shear_zero, keep_x, keep_y;

   // truncating fixed-point product, floor of full product over 2^FRAC_BITS
   function automatic logic signed [abb_pkg::PROD_W-1:0] qmul(
      input logic signed [abb_pkg::VAL_W-1:0] p,
      input logic signed [abb_pkg::VAL_W-1:0] q
   );
      logic signed [abb_pkg::MUL_W-1:0] m;
      m = abb_pkg::MUL_W'(p) * abb_pkg::MUL_W'(q);
      return m[abb_pkg::MUL_W-1:abb_pkg::FRAC_BITS];
   endfunction

   function automatic logic signed [abb_pkg::SUM_W-1:0] smin(
      input logic signed [abb_pkg::SUM_W-1:0] p,
      input logic signed [abb_pkg::SUM_W-1:0] q
   );
      return (q < p) ? q : p;
   endfunction

   function automatic logic signed [abb_pkg::SUM_W-1:0] smax(
      input logic signed [abb_pkg::SUM_W-1:0] p,
      input logic signed [abb_pkg::SUM_W-1:0] q
   );
      return (q > p) ? q : p;
   endfunction

   // register writes and reads
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff   <= abb_pkg::Q_ONE;
         coef_b_ff   <= '0;
         coef_c_ff   <= '0;
         coef_d_ff   <= abb_pkg::Q_ONE;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (wr_en) begin
         case (paddr[abb_pkg::ADDR_W-1:2])
            abb_pkg::REG_COEF_A:   coef_a_ff   <= pwdata;
            abb_pkg::REG_COEF_B:   coef_b_ff   <= pwdata;
            abb_pkg::REG_COEF_C:   coef_c_ff   <= pwdata;
            abb_pkg::REG_COEF_D:   coef_d_ff   <= pwdata;
            abb_pkg::REG_OFFSET_X: offset_x_ff <= pwdata;
            abb_pkg::REG_OFFSET_Y: offset_y_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[abb_pkg::ADDR_W-1:2])
         abb_pkg::REG_COEF_A:   prdata = coef_a_ff;
         abb_pkg::REG_COEF_B:   prdata = coef_b_ff;
         abb_pkg::REG_COEF_C:   prdata = coef_c_ff;
         abb_pkg::REG_COEF_D:   prdata = coef_d_ff;
         abb_pkg::REG_OFFSET_X: prdata = offset_x_ff;
         abb_pkg::REG_OFFSET_Y: prdata = offset_y_ff;
         default:               prdata = '0;
      endcase
   end

   // unit scale without shear keeps the axis pair in input order
   assign shear_zero = (coef_b_ff == '0) && (coef_c_ff == '0);
   assign keep_x     = shear_zero && (coef_a_ff == abb_pkg::Q_ONE);
   assign keep_y     = shear_zero && (coef_d_ff == abb_pkg::Q_ONE);

   // a stage is free when empty or when the stage after it moves on
   assign free[4] = !vld_ff[4] || !rsp_stall;
   assign free[3] = !vld_ff[3] || free[4];
   assign free[2] = !vld_ff[2] || free[3];
   assign free[1] = !vld_ff[1] || free[2];
   assign free[0] = !vld_ff[0] || free[1];

   assign req_stall = !free[0];

   always_comb begin
      vld_in[0] = free[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = free[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (free[0] && req_valid) begin
         in_ff <= req_data;
      end
   end

   // products: eight independent multipliers
   always_ff @(posedge clock) begin
      if (free[1] && vld_ff[0]) begin
         p_ax1_ff <= qmul(coef_a_ff, in_ff.x_first);
         p_ax2_ff <= qmul(coef_a_ff, in_ff.x_second);
         p_cy1_ff <= qmul(coef_c_ff, in_ff.y_first);
         p_cy2_ff <= qmul(coef_c_ff, in_ff.y_second);
         p_bx1_ff <= qmul(coef_b_ff, in_ff.x_first);
         p_bx2_ff <= qmul(coef_b_ff, in_ff.x_second);
         p_dy1_ff <= qmul(coef_d_ff, in_ff.y_first);
         p_dy2_ff <= qmul(coef_d_ff, in_ff.y_second);
      end
   end

   // mapped corners: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
   always_ff @(posedge clock) begin
      if (free[2] && vld_ff[1]) begin
         qx_ff[0] <= abb_pkg::SUM_W'(p_ax1_ff) + abb_pkg::SUM_W'(p_cy1_ff)
                     + abb_pkg::SUM_W'(offset_x_ff);
         qx_ff[1] <= abb_pkg::SUM_W'(p_ax2_ff) + abb_pkg::SUM_W'(p_cy1_ff)
                     + abb_pkg::SUM_W'(offset_x_ff);
         qx_ff[2] <= abb_pkg::SUM_W'(p_ax1_ff) + abb_pkg::SUM_W'(p_cy2_ff)
                     + abb_pkg::SUM_W'(offset_x_ff);
         qx_ff[3] <= abb_pkg::SUM_W'(p_ax2_ff) + abb_pkg::SUM_W'(p_cy2_ff)
                     + abb_pkg::SUM_W'(offset_x_ff);
         qy_ff[0] <= abb_pkg::SUM_W'(p_bx1_ff) + abb_pkg::SUM_W'(p_dy1_ff)
                     + abb_pkg::SUM_W'(offset_y_ff);
         qy_ff[1] <= abb_pkg::SUM_W'(p_bx2_ff) + abb_pkg::SUM_W'(p_dy1_ff)
                     + abb_pkg::SUM_W'(offset_y_ff);
         qy_ff[2] <= abb_pkg::SUM_W'(p_bx1_ff) + abb_pkg::SUM_W'(p_dy2_ff)
                     + abb_pkg::SUM_W'(offset_y_ff);
         qy_ff[3] <= abb_pkg::SUM_W'(p_bx2_ff) + abb_pkg::SUM_W'(p_dy2_ff)
                     + abb_pkg::SUM_W'(offset_y_ff);
      end
   end

   // pairwise bounds: x pairs differ in x, y pairs differ in y
   always_ff @(posedge clock) begin
      if (free[3] && vld_ff[2]) begin
         xlo_a_ff <= keep_x ? qx_ff[0] : smin(qx_ff[0], qx_ff[1]);
         xhi_a_ff <= keep_x ? qx_ff[1] : smax(qx_ff[0], qx_ff[1]);
         xlo_b_ff <= keep_x ? qx_ff[2] : smin(qx_ff[2], qx_ff[3]);
         xhi_b_ff <= keep_x ? qx_ff[3] : smax(qx_ff[2], qx_ff[3]);
         ylo_a_ff <= keep_y ? qy_ff[0] : smin(qy_ff[0], qy_ff[2]);
         yhi_a_ff <= keep_y ? qy_ff[2] : smax(qy_ff[0], qy_ff[2]);
         ylo_b_ff <= keep_y ? qy_ff[1] : smin(qy_ff[1], qy_ff[3]);
         yhi_b_ff <= keep_y ? qy_ff[3] : smax(qy_ff[1], qy_ff[3]);
      end
   end

   // final bounds and saturation into the result register
   always_ff @(posedge clock) begin
      if (free[4] && vld_ff[3]) begin
         rsp_ff.x_low  <= abb_pkg::sat_val(smin(xlo_a_ff, xlo_b_ff));
         rsp_ff.x_high <= abb_pkg::sat_val(smax(xhi_a_ff, xhi_b_ff));
         rsp_ff.y_low  <= abb_pkg::sat_val(smin(ylo_a_ff, ylo_b_ff));
         rsp_ff.y_high <= abb_pkg::sat_val(smax(yhi_a_ff, yhi_b_ff));
      end
   end

   assign rsp_valid = vld_ff[4];
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/abb_checker.sv -----
// ----------------------------------------------------------------------------
// abb_checker
// Port-level checks for the affine box bounds block, bound to the top level.
// ----------------------------------------------------------------------------
module abb_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_stall,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  abb_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [abb_pkg::ADDR_W-1:0]  paddr,
   input  logic [abb_pkg::VAL_W-1:0]   pwdata,
   input  logic [abb_pkg::VAL_W-1:0]   prdata,
   input  logic                        pready
);

   logic reg_write;

   assign reg_write = psel && penable && pwrite && pready
                      && (paddr[abb_pkg::ADDR_W-1:2] <= abb_pkg::REG_OFFSET_Y);

   // a held result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty output stage means the whole pipeline can take input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // a written register reads back its value
   a_readback: assert property (@(posedge clock) disable iff (reset)
      reg_write |=> (paddr != $past(paddr)) || (prdata == $past(pwdata)))
      else $error("register readback mismatch");

endmodule

bind affine_box_bounds abb_checker u_abb_checker (.*);
